>>> design/hxpr_pkg.sv
// Shared constants and controller/datapath interface types for the
// header XOR packet receiver. No dependencies.
package hxpr_pkg;

	localparam int PACKET_BYTES = 32;
	localparam int IDX_W = $clog2(PACKET_BYTES);
	localparam int BYTE_INDEX_W = 6;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PACKET_BYTES - 1);

	localparam logic [7:0] HDR_FIRST = 8'h56;
	localparam logic [7:0] HDR_SECOND = 8'h53;
	localparam logic [31:0] TIMEOUT_RESET = 32'd500;

	localparam logic OP_BYTE = 1'b0;
	localparam logic OP_TICK = 1'b1;

	typedef struct packed {
		logic capture;
		logic process;
		logic check;
		logic rd_load;
		logic idx_incr;
	} hxpr_cmd_t;

	typedef struct packed {
		logic good;
		logic last;
	} hxpr_status_t;

endpackage

>>> design/hxpr_datapath.sv
// Datapath of the header XOR packet receiver: deframing state, packet memory,
// counters, timeout register and result fields. Depends on hxpr_pkg.
module hxpr_datapath (
	input  logic                    clk,
	input  logic                    arst_n,
	input  hxpr_pkg::hxpr_cmd_t     cmd,
	output hxpr_pkg::hxpr_status_t  status,
	input  logic                    cfg_we,
	input  logic [31:0]             cfg_data,
	input  logic                    opcode,
	input  logic [7:0]              rx_byte,
	output logic [7:0]              data_byte,
	output logic [5:0]              byte_index,
	output logic                    last,
	output logic                    packet_good,
	output logic                    checksum_error,
	output logic                    data_fresh,
	output logic [31:0]             good_count,
	output logic [31:0]             bad_count,
	output logic [31:0]             age_ms
);
	import hxpr_pkg::*;

	logic [7:0]       store_mem [PACKET_BYTES];
	logic             op_q;
	logic [7:0]       byte_q;
	logic [31:0]      timeout_q;
	logic [IDX_W-1:0] fill_q;
	logic [7:0]       xor_q;
	logic             valid_q;
	logic [31:0]      good_cnt_q;
	logic [31:0]      bad_cnt_q;
	logic [31:0]      age_q;
	logic             good_q;
	logic             bad_q;
	logic [IDX_W-1:0] idx_q;
	logic [7:0]       rd_q;
	logic             mem_we;
	logic             idx_last;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q <= opcode;
			byte_q <= rx_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= TIMEOUT_RESET;
		end else if (cfg_we) begin
			timeout_q <= cfg_data;
		end
	end

	always_comb begin
		mem_we = 1'b0;
		if (cmd.process && op_q == OP_BYTE) begin
			if (fill_q == '0) begin
				mem_we = (byte_q == HDR_FIRST);
			end else if (fill_q == IDX_W'(1)) begin
				mem_we = (byte_q == HDR_SECOND);
			end else begin
				mem_we = 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			store_mem[fill_q] <= byte_q;
		end
		if (cmd.rd_load) begin
			rd_q <= store_mem[idx_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			xor_q <= '0;
			valid_q <= 1'b0;
			good_cnt_q <= '0;
			bad_cnt_q <= '0;
			age_q <= '0;
			good_q <= 1'b0;
			bad_q <= 1'b0;
			idx_q <= '0;
		end else begin
			if (cmd.process) begin
				good_q <= 1'b0;
				bad_q <= 1'b0;
				idx_q <= '0;
				if (op_q == OP_TICK) begin
					if (age_q != '1) begin
						age_q <= age_q + 32'd1;
					end
				end else if (fill_q == '0) begin
					if (byte_q == HDR_FIRST) begin
						xor_q <= byte_q;
						fill_q <= IDX_W'(1);
					end
				end else if (fill_q == IDX_W'(1)) begin
					if (byte_q == HDR_SECOND) begin
						xor_q <= xor_q ^ byte_q;
						fill_q <= IDX_W'(2);
					end else begin
						xor_q <= '0;
						fill_q <= '0;
					end
				end else if (fill_q == LAST_IDX) begin
					if (xor_q == byte_q) begin
						good_q <= 1'b1;
						good_cnt_q <= good_cnt_q + 32'd1;
						valid_q <= 1'b1;
						age_q <= '0;
					end else begin
						bad_q <= 1'b1;
						bad_cnt_q <= bad_cnt_q + 32'd1;
					end
					xor_q <= '0;
					fill_q <= '0;
				end else begin
					xor_q <= xor_q ^ byte_q;
					fill_q <= fill_q + IDX_W'(1);
				end
			end
			if (cmd.check && valid_q && age_q > timeout_q) begin
				valid_q <= 1'b0;
			end
			if (cmd.idx_incr) begin
				idx_q <= idx_q + IDX_W'(1);
			end
		end
	end

	assign idx_last = (idx_q == LAST_IDX);
	assign status.good = good_q;
	assign status.last = idx_last;

	assign data_byte = good_q ? rd_q : 8'd0;
	assign byte_index = good_q ? BYTE_INDEX_W'(idx_q) : BYTE_INDEX_W'(0);
	assign last = good_q ? idx_last : 1'b1;
	assign packet_good = good_q;
	assign checksum_error = bad_q;
	assign data_fresh = valid_q;
	assign good_count = good_cnt_q;
	assign bad_count = bad_cnt_q;
	assign age_ms = age_q;

endmodule

>>> design/hxpr_controller.sv
// Sequencing state machine of the header XOR packet receiver: handshakes and
// datapath commands. Depends on hxpr_pkg.
module hxpr_controller (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    item_valid,
	output logic                    item_stall,
	output logic                    result_valid,
	input  logic                    result_stall,
	output hxpr_pkg::hxpr_cmd_t     cmd,
	input  hxpr_pkg::hxpr_status_t  status
);
	import hxpr_pkg::*;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_PROC  = 3'd1;
	localparam logic [2:0] S_CHECK = 3'd2;
	localparam logic [2:0] S_LOAD  = 3'd3;
	localparam logic [2:0] S_SHOW  = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;

	always_comb begin
		state_d = state_q;
		cmd = '0;
		item_stall = 1'b1;
		result_valid = 1'b0;
		case (state_q)
			S_IDLE: begin
				item_stall = 1'b0;
				if (item_valid) begin
					cmd.capture = 1'b1;
					state_d = S_PROC;
				end
			end
			S_PROC: begin
				cmd.process = 1'b1;
				state_d = S_CHECK;
			end
			S_CHECK: begin
				cmd.check = 1'b1;
				state_d = status.good ? S_LOAD : S_SHOW;
			end
			S_LOAD: begin
				cmd.rd_load = 1'b1;
				state_d = S_SHOW;
			end
			S_SHOW: begin
				result_valid = 1'b1;
				if (!result_stall) begin
					if (status.good && !status.last) begin
						cmd.idx_incr = 1'b1;
						state_d = S_LOAD;
					end else begin
						state_d = S_IDLE;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

>>> design/header_xor_packet_receiver.sv
// Top level of the header XOR packet receiver: controller plus datapath.
// Depends on hxpr_pkg, hxpr_controller and hxpr_datapath.
//
// Items are received bytes (opcode 0) or millisecond ticks (opcode 1). Bytes
// are framed on the header 'V','S' into packets of PACKET_BYTES bytes whose
// last byte is the XOR of all the others. One item is handled at a time:
// item_stall is low only while the block is idle. An item that gives a single
// result passes through the PROC and CHECK states after acceptance and is
// offered in the SHOW state, held there while result_stall is high. A good
// packet gives a run of PACKET_BYTES results; each is first read in a LOAD
// state through the registered single read port of the packet memory and
// then offered in SHOW. The timeout register may be written at any time the
// block is idle; its reset value is 500 ms.
module header_xor_packet_receiver (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [31:0] cfg_data,
	input  logic        item_valid,
	output logic        item_stall,
	input  logic        opcode,
	input  logic [7:0]  rx_byte,
	output logic        result_valid,
	input  logic        result_stall,
	output logic [7:0]  data_byte,
	output logic [5:0]  byte_index,
	output logic        last,
	output logic        packet_good,
	output logic        checksum_error,
	output logic        data_fresh,
	output logic [31:0] good_count,
	output logic [31:0] bad_count,
	output logic [31:0] age_ms
);
	import hxpr_pkg::*;

	hxpr_cmd_t    cmd;
	hxpr_status_t status;

	hxpr_controller u_controller (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.cmd          (cmd),
		.status       (status)
	);

	hxpr_datapath u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.status         (status),
		.cfg_we         (cfg_we),
		.cfg_data       (cfg_data),
		.opcode         (opcode),
		.rx_byte        (rx_byte),
		.data_byte      (data_byte),
		.byte_index     (byte_index),
		.last           (last),
		.packet_good    (packet_good),
		.checksum_error (checksum_error),
		.data_fresh     (data_fresh),
		.good_count     (good_count),
		.bad_count      (bad_count),
		.age_ms         (age_ms)
	);

endmodule

>>> tb/tb_top.sv
// Self-checking testbench for header_xor_packet_receiver: directed table, then random
// phases of framed packets, noise and ticks under several timeout settings.
// Depends on hxpr_pkg and the RTL of the receiver.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import hxpr_pkg::*;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int HOLD_CYCLES = 300;
	localparam int DRAIN_CYCLES = 8;
	localparam int TAIL_CYCLES = 20;
	localparam int PHASE_ITEMS = 30;
	localparam int NUM_PHASES = 7;
	localparam int NUM_DIRECTED = 21;
	localparam int MAX_REPORTS = 10;

	typedef struct packed {
		logic [7:0]  data_byte;
		logic [5:0]  byte_index;
		logic        last;
		logic        packet_good;
		logic        checksum_error;
		logic        data_fresh;
		logic [31:0] good_count;
		logic [31:0] bad_count;
		logic [31:0] age_ms;
	} result_t;

	typedef struct packed {
		logic        op;
		logic [7:0]  rx;
		bit          typed;
		logic        valid;
		logic [31:0] age;
		logic [31:0] good;
		logic [31:0] bad;
		logic        err;
	} stim_row_t;

	localparam result_t NO_TYPED = '0;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [31:0] cfg_data;
	logic        item_valid;
	logic        item_stall;
	logic        opcode;
	logic [7:0]  rx_byte;
	logic        result_valid;
	logic        result_stall;
	logic [7:0]  data_byte;
	logic [5:0]  byte_index;
	logic        last;
	logic        packet_good;
	logic        checksum_error;
	logic        data_fresh;
	logic [31:0] good_count;
	logic [31:0] bad_count;
	logic [31:0] age_ms;

	header_xor_packet_receiver u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_data       (cfg_data),
		.item_valid     (item_valid),
		.item_stall     (item_stall),
		.opcode         (opcode),
		.rx_byte        (rx_byte),
		.result_valid   (result_valid),
		.result_stall   (result_stall),
		.data_byte      (data_byte),
		.byte_index     (byte_index),
		.last           (last),
		.packet_good    (packet_good),
		.checksum_error (checksum_error),
		.data_fresh     (data_fresh),
		.good_count     (good_count),
		.bad_count      (bad_count),
		.age_ms         (age_ms)
	);

	// Predictor copy of the receiver state
	int          rx_fill;
	logic [7:0]  rx_xor;
	logic [7:0]  rx_store [PACKET_BYTES];
	logic        rx_valid;
	logic [31:0] rx_good;
	logic [31:0] rx_bad;
	logic [31:0] rx_age;
	logic [31:0] rx_timeout;
	result_t     predicted_run [PACKET_BYTES];

	result_t     expected_results [$];
	bit          idle_on;
	bit          hold_req;
	int          items_sent;
	int          results_checked;
	int          mismatches;
	int          settings_used;
	int          holds_done;
	int          idle_cycles;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int predict_item(input logic op, input logic [7:0] b);
		bit good;
		bit bad;
		int n;
		good = 1'b0;
		bad = 1'b0;
		if (op == OP_TICK) begin
			if (rx_age != 32'hFFFF_FFFF)
				rx_age = rx_age + 32'd1;
		end else if (rx_fill == 0) begin
			if (b == HDR_FIRST) begin
				rx_store[0] = b;
				rx_xor = b;
				rx_fill = 1;
			end
		end else if (rx_fill == 1) begin
			if (b == HDR_SECOND) begin
				rx_store[1] = b;
				rx_xor = rx_xor ^ b;
				rx_fill = 2;
			end else begin
				rx_fill = 0;
				rx_xor = 8'h00;
			end
		end else begin
			rx_store[rx_fill] = b;
			if (rx_fill == PACKET_BYTES - 1) begin
				if (rx_xor == b) begin
					good = 1'b1;
					rx_good = rx_good + 32'd1;
					rx_valid = 1'b1;
					rx_age = 32'd0;
				end else begin
					bad = 1'b1;
					rx_bad = rx_bad + 32'd1;
				end
				rx_fill = 0;
				rx_xor = 8'h00;
			end else begin
				rx_xor = rx_xor ^ b;
				rx_fill = rx_fill + 1;
			end
		end
		if (rx_valid && rx_age > rx_timeout)
			rx_valid = 1'b0;
		n = good ? PACKET_BYTES : 1;
		for (int k = 0; k < n; k++) begin
			predicted_run[k] = '{
				data_byte: good ? rx_store[k] : 8'h00,
				byte_index: 6'(k),
				last: (k == n - 1),
				packet_good: good,
				checksum_error: bad,
				data_fresh: rx_valid,
				good_count: rx_good,
				bad_count: rx_bad,
				age_ms: rx_age
			};
		end
		return n;
	endfunction

	function automatic int sender_gap();
		int sel;
		sel = $urandom_range(0, 19);
		if (!idle_on || sel < 12)
			return 0;
		if (sel < 19)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic string fmt_result(input result_t r);
		return {$sformatf("data=%h idx=%0d last=%b good=%b err=%b", r.data_byte,
			r.byte_index, r.last, r.packet_good, r.checksum_error),
			$sformatf(" fresh=%b gcnt=%0d bcnt=%0d age=%0d", r.data_fresh,
			r.good_count, r.bad_count, r.age_ms)};
	endfunction

	task automatic send_item(input logic op, input logic [7:0] b, input bit use_typed,
		input result_t typed);
		int n;
		int gap;
		gap = sender_gap();
		repeat (gap) begin
			@(negedge clk);
			item_valid <= 1'b0;
		end
		@(negedge clk);
		item_valid <= 1'b1;
		opcode <= op;
		rx_byte <= b;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
		items_sent++;
		n = predict_item(op, b);
		if (use_typed)
			expected_results.push_back(typed);
		else
			for (int k = 0; k < n; k++)
				expected_results.push_back(predicted_run[k]);
	endtask

	task automatic drain_results();
		@(negedge clk);
		item_valid <= 1'b0;
		while (expected_results.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_timeout(input logic [31:0] value);
		drain_results();
		cfg_we <= 1'b1;
		cfg_data <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		rx_timeout = value;
		settings_used++;
	endtask

	task automatic report_mismatch(input string what, input result_t want, input result_t got);
		mismatches++;
		if (mismatches <= MAX_REPORTS)
			$display("%0t %s: want %s | got %s", $realtime, what, fmt_result(want),
				fmt_result(got));
	endtask

	always @(posedge clk) begin
		result_t got;
		result_t want;
		if (arst_n && result_valid && !result_stall) begin
			got = '{data_byte, byte_index, last, packet_good, checksum_error, data_fresh,
				good_count, bad_count, age_ms};
			results_checked++;
			if (expected_results.size() == 0) begin
				report_mismatch("result transaction with none expected", NO_TYPED, got);
			end else begin
				want = expected_results.pop_front();
				if (got !== want)
					report_mismatch("result mismatch", want, got);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((item_valid && !item_stall) || (result_valid && !result_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	initial begin
		int len;
		int sel;
		result_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req && holds_done == 0) begin
				result_stall <= 1'b1;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
				holds_done++;
			end else if (idle_on && $urandom_range(0, 3) == 0) begin
				result_stall <= 1'b1;
				sel = $urandom_range(0, 19);
				len = (sel == 0) ? $urandom_range(20, 60) : $urandom_range(1, 3);
				repeat (len - 1) @(negedge clk);
			end else begin
				result_stall <= 1'b0;
			end
		end
	end

	initial begin
		stim_row_t   directed_rows [NUM_DIRECTED];
		result_t     typed;
		logic [7:0]  pkt [PACKET_BYTES];
		logic [7:0]  chk;
		logic [31:0] phase_timeout [NUM_PHASES];
		int          sel;
		int          n;
		int          phase_end;

		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_data = 32'd0;
		item_valid = 1'b0;
		opcode = OP_BYTE;
		rx_byte = 8'h00;
		idle_on = 1'b1;
		hold_req = 1'b0;

		rx_fill = 0;
		rx_xor = 8'h00;
		rx_valid = 1'b0;
		rx_good = 32'd0;
		rx_bad = 32'd0;
		rx_age = 32'd0;
		rx_timeout = TIMEOUT_RESET;

		directed_rows = '{
			'{OP_TICK, 8'h00,      1'b1, 1'b0, 32'd1, 32'd0, 32'd0, 1'b0},
			'{OP_TICK, 8'hFF,      1'b1, 1'b0, 32'd2, 32'd0, 32'd0, 1'b0},
			'{OP_BYTE, 8'h00,      1'b1, 1'b0, 32'd2, 32'd0, 32'd0, 1'b0},
			'{OP_BYTE, 8'hFF,      1'b1, 1'b0, 32'd2, 32'd0, 32'd0, 1'b0},
			'{OP_BYTE, HDR_SECOND, 1'b1, 1'b0, 32'd2, 32'd0, 32'd0, 1'b0},
			'{OP_BYTE, HDR_FIRST,  1'b1, 1'b0, 32'd2, 32'd0, 32'd0, 1'b0},
			'{OP_BYTE, HDR_FIRST,  1'b1, 1'b0, 32'd2, 32'd0, 32'd0, 1'b0},
			'{OP_BYTE, HDR_SECOND, 1'b1, 1'b0, 32'd2, 32'd0, 32'd0, 1'b0},
			'{OP_BYTE, HDR_FIRST,  1'b1, 1'b0, 32'd2, 32'd0, 32'd0, 1'b0},
			'{OP_BYTE, 8'hFF,      1'b1, 1'b0, 32'd2, 32'd0, 32'd0, 1'b0},
			'{OP_BYTE, HDR_FIRST,  1'b1, 1'b0, 32'd2, 32'd0, 32'd0, 1'b0},
			'{OP_TICK, 8'h53,      1'b1, 1'b0, 32'd3, 32'd0, 32'd0, 1'b0},
			'{OP_BYTE, HDR_SECOND, 1'b1, 1'b0, 32'd3, 32'd0, 32'd0, 1'b0},
			'{OP_TICK, 8'hA5,      1'b1, 1'b0, 32'd4, 32'd0, 32'd0, 1'b0},
			'{OP_BYTE, 8'h00,      1'b0, 1'b0, 32'd0, 32'd0, 32'd0, 1'b0},
			'{OP_BYTE, 8'hFF,      1'b0, 1'b0, 32'd0, 32'd0, 32'd0, 1'b0},
			'{OP_BYTE, HDR_FIRST,  1'b0, 1'b0, 32'd0, 32'd0, 32'd0, 1'b0},
			'{OP_BYTE, HDR_SECOND, 1'b0, 1'b0, 32'd0, 32'd0, 32'd0, 1'b0},
			'{OP_TICK, 8'h00,      1'b0, 1'b0, 32'd0, 32'd0, 32'd0, 1'b0},
			'{OP_BYTE, 8'hAA,      1'b0, 1'b0, 32'd0, 32'd0, 32'd0, 1'b0},
			'{OP_BYTE, 8'h55,      1'b0, 1'b0, 32'd0, 32'd0, 32'd0, 1'b0}
		};

		phase_timeout = '{TIMEOUT_RESET, 32'd0, 32'hFFFF_FFFF, 32'd3, $urandom(),
			$urandom_range(1, 12), 32'd1};

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[i]) begin
			typed = '{
				data_byte: 8'h00,
				byte_index: 6'd0,
				last: 1'b1,
				packet_good: 1'b0,
				checksum_error: directed_rows[i].err,
				data_fresh: directed_rows[i].valid,
				good_count: directed_rows[i].good,
				bad_count: directed_rows[i].bad,
				age_ms: directed_rows[i].age
			};
			send_item(directed_rows[i].op, directed_rows[i].rx, directed_rows[i].typed, typed);
		end

		for (int phase = 0; phase < NUM_PHASES; phase++) begin
			write_timeout(phase_timeout[phase]);
			idle_on = (phase != 0);
			if (phase == 2) begin
				@(posedge clk);
				hold_req = 1'b1;
			end
			phase_end = items_sent + PHASE_ITEMS;
			while (items_sent < phase_end) begin
				sel = $urandom_range(0, 99);
				if (sel < 3) begin
					drain_results();
				end else if (sel < 60) begin
					while (rx_fill != 0)
						send_item(OP_BYTE, 8'($urandom_range(0, 255)), 1'b0, NO_TYPED);
					pkt[0] = HDR_FIRST;
					pkt[1] = HDR_SECOND;
					chk = HDR_FIRST ^ HDR_SECOND;
					for (int k = 2; k < PACKET_BYTES - 1; k++) begin
						pkt[k] = 8'($urandom_range(0, 255));
						chk = chk ^ pkt[k];
					end
					if ($urandom_range(0, 4) == 0)
						chk = chk ^ 8'($urandom_range(1, 255));
					pkt[PACKET_BYTES - 1] = chk;
					for (int k = 0; k < PACKET_BYTES; k++) begin
						if ($urandom_range(0, 9) == 0)
							send_item(OP_TICK, 8'($urandom_range(0, 255)), 1'b0, NO_TYPED);
						send_item(OP_BYTE, pkt[k], 1'b0, NO_TYPED);
					end
				end else if (sel < 72) begin
					send_item(OP_BYTE, HDR_FIRST, 1'b0, NO_TYPED);
					chk = $urandom_range(0, 1) ? HDR_FIRST : 8'($urandom_range(0, 255));
					if (chk == HDR_SECOND)
						chk = ~chk;
					send_item(OP_BYTE, chk, 1'b0, NO_TYPED);
				end else if (sel < 86) begin
					n = $urandom_range(1, 6);
					repeat (n)
						send_item(OP_BYTE, 8'($urandom_range(0, 255)), 1'b0, NO_TYPED);
				end else begin
					n = $urandom_range(1, 6);
					repeat (n)
						send_item(OP_TICK, 8'($urandom_range(0, 255)), 1'b0, NO_TYPED);
				end
			end
			n = $urandom_range(2, 6);
			repeat (n) send_item(OP_TICK, 8'($urandom_range(0, 255)), 1'b0, NO_TYPED);
		end

		drain_results();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Covered %0d byte and tick transactions and %0d result transactions;",
			items_sent, results_checked);
		$display("%0d good and %0d bad packets, %0d timeout settings, %0d receiver hold-off(s).",
			rx_good, rx_bad, settings_used, holds_done);
		if (expected_results.size() != 0)
			$display("%0d expected result transactions never arrived",
				expected_results.size());
		if (mismatches == 0 && expected_results.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

>>> header_xor_packet_receiver.f
design/hxpr_pkg.sv
design/hxpr_datapath.sv
design/hxpr_controller.sv
design/header_xor_packet_receiver.sv
tb/tb_top.sv
